@@ rtl/skr_pkg.sv @@
// skr_pkg: shared types, codes and helpers for the session keypair rotation block.
// No dependencies; every rtl file refers to it by scoped names.

package skr_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CTR_W   = 64;
    localparam int unsigned IDX_W   = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Slot positions
    localparam logic [1:0] SL_NEXT = 2'd0;
    localparam logic [1:0] SL_CUR  = 2'd1;
    localparam logic [1:0] SL_PREV = 2'd2;
    localparam int unsigned NSLOTS = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_MSGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REKEY_MSGS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REKEY_TIME  = 2'd3;

    // Configuration reset values
    localparam logic [CTR_W-1:0]   RST_REJECT_MSGS = 64'hFFFF_FFFF_FFFF_DFFF;
    localparam logic [CTR_W-1:0]   RST_REKEY_MSGS  = 64'h1000_0000_0000_0000;
    localparam logic [LIMIT_W-1:0] RST_REJECT_TIME = 16'd180;
    localparam logic [LIMIT_W-1:0] RST_REKEY_TIME  = 16'd120;

    typedef enum logic [2:0] {
        OP_BEGIN  = 3'd0,
        OP_EXPIRE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SEND   = 3'd3,
        OP_RECV   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_RESP = 2'd1,
        ROLE_INIT = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FRESH = 2'd1,
        ST_FAIL  = 2'd2
    } status_t;

    // One request as held in the input register
    typedef struct packed {
        logic [2:0]        op;
        logic [TIME_W-1:0] now_time;
        logic [1:0]        handshake_role;
        logic [IDX_W-1:0]  local_index;
        logic [IDX_W-1:0]  peer_index;
        logic [CTR_W-1:0]  recv_count;
    } req_t;

    // One result as held in the output register
    typedef struct packed {
        logic [1:0]       status;
        logic [CTR_W-1:0] nonce;
        logic [IDX_W-1:0] remote_index;
        logic             ready_res;
    } res_t;

    // Configuration register set
    typedef struct packed {
        logic [CTR_W-1:0]   reject_msgs;
        logic [CTR_W-1:0]   rekey_msgs;
        logic [LIMIT_W-1:0] reject_time;
        logic [LIMIT_W-1:0] rekey_time;
    } cfg_t;

    // Per-slot data fields (no reset; read only while the slot is present)
    typedef struct packed {
        logic [TIME_W-1:0] birth;
        logic [CTR_W-1:0]  send_ctr;
        logic [CTR_W-1:0]  recv_ctr;
        logic [IDX_W-1:0]  local_idx;
        logic [IDX_W-1:0]  remote_idx;
    } slot_data_t;

    // Birth plus limit compared against now, computed one bit wider so it never wraps
    function automatic logic aged_past(input logic [TIME_W-1:0] birth,
                                       input logic [LIMIT_W-1:0] limit,
                                       input logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        sum = {1'b0, birth} + {{(TIME_W+1-LIMIT_W){1'b0}}, limit};
        return sum < {1'b0, now};
    endfunction

endpackage

@@ rtl/session_keypair_rotation_top.sv @@
// session_keypair_rotation_top: top level with result register and checks.
// Depends on skr_pkg, skr_cfg, skr_in_stage and skr_exec.
//
// Usage:
//   Requests enter on in_valid/in_ready with op, now_time, handshake_role,
//   local_index, peer_index and recv_count. Each request yields exactly one
//   result on out_valid/out_ready: status, nonce, remote_index, ready_res.
//   A request is captured in an input register; once the output register is
//   free, the slot state is read, updated and the result is loaded into the
//   output register. Throughput is one request per cycle while out_ready
//   stays high. The slot state is read and rewritten as each request executes,
//   so every request sees the state that the previous one left.
//   When the receiver stalls, the result holds in the output register while a
//   further request can still wait in the input register; in_ready falls only
//   when both are full.
//   Limits are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   0..3 and cfg_data; the user must write them only while no request is in
//   flight; the block does not enforce it. Reset (rst_n low, asynchronous)
//   empties all slots, drops any request in flight, restores default limits.

module session_keypair_rotation_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       op,
    input  logic [skr_pkg::TIME_W-1:0]       now_time,
    input  logic [1:0]                       handshake_role,
    input  logic [skr_pkg::IDX_W-1:0]        local_index,
    input  logic [skr_pkg::IDX_W-1:0]        peer_index,
    input  logic [skr_pkg::CTR_W-1:0]        recv_count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [skr_pkg::CTR_W-1:0]        nonce,
    output logic [skr_pkg::IDX_W-1:0]        remote_index,
    output logic                             ready_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [skr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [skr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    skr_pkg::req_t in_req;
    skr_pkg::req_t held_req;
    skr_pkg::cfg_t cfg;
    skr_pkg::res_t res;
    skr_pkg::res_t res_reg;
    logic          held_valid;
    logic          advance;
    logic          out_v_reg;
    logic          out_v_next;

    assign in_req.op             = op;
    assign in_req.now_time       = now_time;
    assign in_req.handshake_role = handshake_role;
    assign in_req.local_index    = local_index;
    assign in_req.peer_index     = peer_index;
    assign in_req.recv_count     = recv_count;

    assign cfg_ready = 1'b1;

    skr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    skr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_req     (in_req),
        .advance    (advance),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    // A held request executes when the result register is free
    assign advance = held_valid && (!out_v_reg || out_ready);

    skr_exec u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (held_req),
        .cfg   (cfg),
        .res   (res)
    );

    // Result register
    assign out_v_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_v_reg;
    assign status       = res_reg.status;
    assign nonce        = res_reg.nonce;
    assign remote_index = res_reg.remote_index;
    assign ready_res    = res_reg.ready_res;

    // Every executed request shows up as a result on the next cycle
    a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("executed request produced no result");

    // A refused or failed request never leaks a nonce or index
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == skr_pkg::ST_FAIL) |-> (nonce == '0 && remote_index == '0))
        else $error("failed result carries nonce or index");

    // After clearing all slots the current keypair cannot be ready
    a_clear_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held_req.op == skr_pkg::OP_CLEAR) |=> !ready_res)
        else $error("ready reported after clear");

    // A held request is never dropped without executing
    a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !advance) |=> (held_valid && $stable(held_req)))
        else $error("held request lost while stalled");

endmodule

@@ rtl/skr_cfg.sv @@
// skr_cfg: configuration register file for the limits.
// Depends on skr_pkg.

module skr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [skr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [skr_pkg::CFG_DATA_W-1:0]   wr_data,
    output skr_pkg::cfg_t                    cfg
);

    skr_pkg::cfg_t cfg_reg;

    // Register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reject_msgs <= skr_pkg::RST_REJECT_MSGS;
            cfg_reg.rekey_msgs  <= skr_pkg::RST_REKEY_MSGS;
            cfg_reg.reject_time <= skr_pkg::RST_REJECT_TIME;
            cfg_reg.rekey_time  <= skr_pkg::RST_REKEY_TIME;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                skr_pkg::CFG_REJECT_MSGS: cfg_reg.reject_msgs <= wr_data;
                skr_pkg::CFG_REKEY_MSGS:  cfg_reg.rekey_msgs  <= wr_data;
                skr_pkg::CFG_REJECT_TIME:
                    cfg_reg.reject_time <= wr_data[skr_pkg::LIMIT_W-1:0];
                skr_pkg::CFG_REKEY_TIME:
                    cfg_reg.rekey_time  <= wr_data[skr_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/skr_in_stage.sv @@
// skr_in_stage: input register with valid/ready handshake.
// Depends on skr_pkg.

module skr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skr_pkg::req_t  in_req,
    input  logic           advance,
    output logic           held_valid,
    output skr_pkg::req_t  held_req
);

    logic          valid_reg;
    logic          valid_next;
    skr_pkg::req_t req_reg;

    // Free when empty or when the held request moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

@@ rtl/skr_exec.sv @@
// skr_exec: the three keypair slots, their rotation and the send admission logic.
// Depends on skr_pkg.

module skr_exec (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  skr_pkg::req_t  req,
    input  skr_pkg::cfg_t  cfg,
    output skr_pkg::res_t  res
);

    logic [skr_pkg::NSLOTS-1:0] present_reg;
    logic [skr_pkg::NSLOTS-1:0] present_next;
    logic [skr_pkg::NSLOTS-1:0] valid_reg;
    logic [skr_pkg::NSLOTS-1:0] valid_next;
    logic [skr_pkg::NSLOTS-1:0] init_reg;
    logic [skr_pkg::NSLOTS-1:0] init_next;
    skr_pkg::slot_data_t        slot_data_reg  [skr_pkg::NSLOTS];
    skr_pkg::slot_data_t        slot_data_next [skr_pkg::NSLOTS];

    skr_pkg::slot_data_t        kp;
    logic [skr_pkg::CTR_W-1:0]  nonce_cand;
    logic                       cur_usable;
    logic                       fresh_hint;

    // Fresh keypair built from the handshake inputs
    always_comb
    begin
        kp.birth      = req.now_time;
        kp.send_ctr   = '0;
        kp.recv_ctr   = '0;
        kp.local_idx  = req.local_index;
        kp.remote_idx = req.peer_index;
    end

    // Checks on the current slot as it stands before this request
    assign nonce_cand = slot_data_reg[skr_pkg::SL_CUR].send_ctr;
    assign cur_usable = present_reg[skr_pkg::SL_CUR] && valid_reg[skr_pkg::SL_CUR]
        && !skr_pkg::aged_past(slot_data_reg[skr_pkg::SL_CUR].birth,
                               cfg.reject_time, req.now_time)
        && (slot_data_reg[skr_pkg::SL_CUR].recv_ctr < cfg.reject_msgs);
    assign fresh_hint = (nonce_cand >= cfg.rekey_msgs)
        || (init_reg[skr_pkg::SL_CUR]
            && skr_pkg::aged_past(slot_data_reg[skr_pkg::SL_CUR].birth,
                                  cfg.rekey_time, req.now_time));

    // Next slot state and result fields
    always_comb
    begin
        present_next     = present_reg;
        valid_next       = valid_reg;
        init_next        = init_reg;
        slot_data_next   = slot_data_reg;
        res.status       = skr_pkg::ST_FAIL;
        res.nonce        = '0;
        res.remote_index = '0;

        if (fire)
        begin
            unique case (skr_pkg::op_t'(req.op))
                skr_pkg::OP_BEGIN:
                begin
                    unique case (skr_pkg::role_t'(req.handshake_role))
                        skr_pkg::ROLE_INIT:
                        begin
                            // Previous takes next if present, else current
                            if (present_reg[skr_pkg::SL_NEXT])
                            begin
                                present_next[skr_pkg::SL_PREV] = 1'b1;
                                valid_next[skr_pkg::SL_PREV] = valid_reg[skr_pkg::SL_NEXT];
                                init_next[skr_pkg::SL_PREV]  = init_reg[skr_pkg::SL_NEXT];
                                slot_data_next[skr_pkg::SL_PREV] =
                                    slot_data_reg[skr_pkg::SL_NEXT];
                                present_next[skr_pkg::SL_NEXT] = 1'b0;
                                valid_next[skr_pkg::SL_NEXT]   = 1'b0;
                                init_next[skr_pkg::SL_NEXT]    = 1'b0;
                            end
                            else
                            begin
                                present_next[skr_pkg::SL_PREV] =
                                    present_reg[skr_pkg::SL_CUR];
                                valid_next[skr_pkg::SL_PREV] = valid_reg[skr_pkg::SL_CUR];
                                init_next[skr_pkg::SL_PREV]  = init_reg[skr_pkg::SL_CUR];
                                slot_data_next[skr_pkg::SL_PREV] =
                                    slot_data_reg[skr_pkg::SL_CUR];
                            end
                            present_next[skr_pkg::SL_CUR]   = 1'b1;
                            valid_next[skr_pkg::SL_CUR]     = 1'b1;
                            init_next[skr_pkg::SL_CUR]      = 1'b1;
                            slot_data_next[skr_pkg::SL_CUR] = kp;
                            res.status = skr_pkg::ST_OK;
                        end
                        skr_pkg::ROLE_RESP:
                        begin
                            // Responder parks the new keypair in next
                            present_next[skr_pkg::SL_PREV]   = 1'b0;
                            valid_next[skr_pkg::SL_PREV]     = 1'b0;
                            init_next[skr_pkg::SL_PREV]      = 1'b0;
                            present_next[skr_pkg::SL_NEXT]   = 1'b1;
                            valid_next[skr_pkg::SL_NEXT]     = 1'b1;
                            init_next[skr_pkg::SL_NEXT]      = 1'b0;
                            slot_data_next[skr_pkg::SL_NEXT] = kp;
                            res.status = skr_pkg::ST_OK;
                        end
                        default: ;
                    endcase
                end
                skr_pkg::OP_EXPIRE:
                begin
                    if (present_reg[skr_pkg::SL_NEXT])
                    begin
                        valid_next[skr_pkg::SL_NEXT] = 1'b0;
                    end
                    if (present_reg[skr_pkg::SL_CUR])
                    begin
                        valid_next[skr_pkg::SL_CUR] = 1'b0;
                    end
                    res.status = skr_pkg::ST_OK;
                end
                skr_pkg::OP_CLEAR:
                begin
                    present_next = '0;
                    valid_next   = '0;
                    init_next    = '0;
                    res.status   = skr_pkg::ST_OK;
                end
                skr_pkg::OP_SEND:
                begin
                    if (cur_usable)
                    begin
                        // Saturating counter advance
                        if (nonce_cand != {skr_pkg::CTR_W{1'b1}})
                        begin
                            slot_data_next[skr_pkg::SL_CUR].send_ctr =
                                nonce_cand + {{(skr_pkg::CTR_W-1){1'b0}}, 1'b1};
                        end
                        if (nonce_cand <= cfg.reject_msgs)
                        begin
                            res.nonce        = nonce_cand;
                            res.remote_index = slot_data_reg[skr_pkg::SL_CUR].remote_idx;
                            res.status = fresh_hint ? skr_pkg::ST_FRESH : skr_pkg::ST_OK;
                        end
                    end
                end
                skr_pkg::OP_RECV:
                begin
                    if (present_reg[skr_pkg::SL_CUR])
                    begin
                        slot_data_next[skr_pkg::SL_CUR].recv_ctr = req.recv_count;
                        res.status = skr_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
        end

        // Readiness of the current slot after this request
        res.ready_res = present_next[skr_pkg::SL_CUR] && valid_next[skr_pkg::SL_CUR]
            && !skr_pkg::aged_past(slot_data_next[skr_pkg::SL_CUR].birth,
                                   cfg.reject_time, req.now_time)
            && (slot_data_next[skr_pkg::SL_CUR].recv_ctr < cfg.reject_msgs)
            && (slot_data_next[skr_pkg::SL_CUR].send_ctr < cfg.reject_msgs);
    end

    // Slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            valid_reg   <= '0;
            init_reg    <= '0;
        end
        else
        begin
            present_reg <= present_next;
            valid_reg   <= valid_next;
            init_reg    <= init_next;
        end
    end

    // Slot data, no reset
    always_ff @(posedge clk)
    begin
        slot_data_reg <= slot_data_next;
    end

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for session_keypair_rotation_top.
// Depends on skr_pkg and the rtl top level; a built-in slot predictor supplies expected results.
// Directed table at reset limits first, then random phases under several limit settings.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import skr_pkg::*;

    // Codes outside the package enums
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;
    localparam logic [1:0] ROLE_BAD  = 2'd3;

    localparam int NUM_PHASES      = 6;
    localparam int RAND_PER_PHASE  = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int MAX_PRINTED     = 40;

    localparam logic [TIME_W-1:0] T_MAX = '1;
    localparam logic [CTR_W-1:0]  C_MAX = '1;

    // One keypair slot as the predictor keeps it
    typedef struct packed {
        logic       present;
        logic       valid;
        logic       initiator;
        slot_data_t data;
    } keypair_t;

    // One line of the directed table
    typedef struct packed {
        req_t rq;
        bit   typed;
        res_t res;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            op;
    logic [TIME_W-1:0]     now_time;
    logic [1:0]            handshake_role;
    logic [IDX_W-1:0]      local_index;
    logic [IDX_W-1:0]      peer_index;
    logic [CTR_W-1:0]      recv_count;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [CTR_W-1:0]      nonce;
    logic [IDX_W-1:0]      remote_index;
    logic                  ready_res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state
    keypair_t kp_slots [NSLOTS];
    cfg_t     limits;

    res_t      due_results [$];
    plan_row_t directed_plan [$];

    int mismatches      = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int sends_total     = 0;
    int sends_refused   = 0;
    int burst_left      = 0;
    int quiet_cycles    = 0;

    session_keypair_rotation_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .now_time       (now_time),
        .handshake_role (handshake_role),
        .local_index    (local_index),
        .peer_index     (peer_index),
        .recv_count     (recv_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .nonce          (nonce),
        .remote_index   (remote_index),
        .ready_res      (ready_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Age test, one bit wider so birth plus limit never wraps
    function automatic bit aged_beyond(input logic [TIME_W-1:0] born,
                                       input logic [LIMIT_W-1:0] lim,
                                       input logic [TIME_W-1:0] t);
        return ({1'b0, born} + {{(TIME_W + 1 - LIMIT_W){1'b0}}, lim}) < {1'b0, t};
    endfunction

    function automatic bit keypair_usable(input keypair_t k, input logic [TIME_W-1:0] t);
        return k.present && k.valid && !aged_beyond(k.data.birth, limits.reject_time, t)
            && (k.data.recv_ctr < limits.reject_msgs);
    endfunction

    // Applies one request to the slot state and returns the result it yields
    function automatic res_t predict_session(input req_t r);
        res_t             res;
        keypair_t         fresh;
        logic [CTR_W-1:0] n;
        res = '0;
        res.status = ST_FAIL;
        case (r.op)
            OP_BEGIN:
            begin
                if (r.handshake_role == ROLE_RESP || r.handshake_role == ROLE_INIT)
                begin
                    fresh = '0;
                    fresh.present = 1'b1;
                    fresh.valid = 1'b1;
                    fresh.initiator = (r.handshake_role == ROLE_INIT);
                    fresh.data.birth = r.now_time;
                    fresh.data.local_idx = r.local_index;
                    fresh.data.remote_idx = r.peer_index;
                    if (fresh.initiator)
                    begin
                        // initiator: new keypair is current at once
                        if (kp_slots[SL_NEXT].present)
                        begin
                            kp_slots[SL_PREV] = kp_slots[SL_NEXT];
                            kp_slots[SL_NEXT] = '0;
                        end
                        else
                        begin
                            kp_slots[SL_PREV] = kp_slots[SL_CUR];
                        end
                        kp_slots[SL_CUR] = fresh;
                    end
                    else
                    begin
                        // responder: park in next, keep current
                        kp_slots[SL_PREV] = '0;
                        kp_slots[SL_NEXT] = fresh;
                    end
                    res.status = ST_OK;
                end
            end
            OP_EXPIRE:
            begin
                if (kp_slots[SL_NEXT].present)
                    kp_slots[SL_NEXT].valid = 1'b0;
                if (kp_slots[SL_CUR].present)
                    kp_slots[SL_CUR].valid = 1'b0;
                res.status = ST_OK;
            end
            OP_CLEAR:
            begin
                foreach (kp_slots[i])
                    kp_slots[i] = '0;
                res.status = ST_OK;
            end
            OP_SEND:
            begin
                if (keypair_usable(kp_slots[SL_CUR], r.now_time))
                begin
                    n = kp_slots[SL_CUR].data.send_ctr;
                    if (n != C_MAX)
                        kp_slots[SL_CUR].data.send_ctr = n + 64'd1;
                    if (n <= limits.reject_msgs)
                    begin
                        res.nonce = n;
                        res.remote_index = kp_slots[SL_CUR].data.remote_idx;
                        if ((kp_slots[SL_CUR].valid && n >= limits.rekey_msgs) ||
                            (kp_slots[SL_CUR].initiator &&
                             aged_beyond(kp_slots[SL_CUR].data.birth, limits.rekey_time,
                                         r.now_time)))
                            res.status = ST_FRESH;
                        else
                            res.status = ST_OK;
                    end
                end
            end
            OP_RECV:
            begin
                if (kp_slots[SL_CUR].present)
                begin
                    kp_slots[SL_CUR].data.recv_ctr = r.recv_count;
                    res.status = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        res.ready_res = keypair_usable(kp_slots[SL_CUR], r.now_time) &&
                        (kp_slots[SL_CUR].data.send_ctr < limits.reject_msgs);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_row(input logic [2:0] o, input logic [TIME_W-1:0] t,
                           input logic [1:0] role, input logic [IDX_W-1:0] lidx,
                           input logic [IDX_W-1:0] pidx, input logic [CTR_W-1:0] rcnt,
                           input bit typed, input logic [1:0] st,
                           input logic [CTR_W-1:0] nc, input logic [IDX_W-1:0] ridx,
                           input logic rdy);
        plan_row_t row;
        row.rq = '{o, t, role, lidx, pidx, rcnt};
        row.typed = typed;
        row.res = '{st, nc, ridx, rdy};
        directed_plan.push_back(row);
    endtask

    // Offers one request in burst/gap rhythm and records its expected result
    task automatic offer_request(input req_t rq, input bit typed, input res_t typed_res);
        int   gap;
        res_t want;
        gap = 0;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
            end
        end
        burst_left--;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= rq.op;
        now_time       <= rq.now_time;
        handshake_role <= rq.handshake_role;
        local_index    <= rq.local_index;
        peer_index     <= rq.peer_index;
        recv_count     <= rq.recv_count;
        do @(posedge clk); while (!in_ready);
        want = predict_session(rq);
        if (typed)
            want = typed_res;
        due_results.push_back(want);
        requests_sent++;
        if (rq.op == OP_SEND)
        begin
            sends_total++;
            if (want.status == ST_FAIL)
                sends_refused++;
        end
    endtask

    // Writes all four limit registers; time limits get junk in the upper bits
    task automatic program_limits(input cfg_t c);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_IDX_W-1:0]  idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = i[CFG_IDX_W-1:0];
            word = {$urandom, $urandom};
            case (idx)
                CFG_REJECT_MSGS: word = c.reject_msgs;
                CFG_REKEY_MSGS:  word = c.rekey_msgs;
                CFG_REJECT_TIME: word[LIMIT_W-1:0] = c.reject_time;
                default:         word[LIMIT_W-1:0] = c.rekey_time;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                CFG_REJECT_MSGS: limits.reject_msgs = word;
                CFG_REKEY_MSGS:  limits.rekey_msgs = word;
                CFG_REJECT_TIME: limits.reject_time = word[LIMIT_W-1:0];
                default:         limits.rekey_time = word[LIMIT_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits for every outstanding result, then lets the pipeline settle
    task automatic drain_results();
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: compare against the oldest expectation, then pick out_ready
    initial
    begin : result_sink
        int   cyc;
        int   hold;
        int   next_hold_at;
        bit   take;
        res_t want;
        cyc = 0;
        hold = 0;
        next_hold_at = 150;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected result status %0d nonce %0h",
                                              status, nonce));
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_checked, status, want.status));
                    if (nonce !== want.nonce)
                        report_mismatch($sformatf("result %0d nonce %0h, want %0h",
                                                  results_checked, nonce, want.nonce));
                    if (remote_index !== want.remote_index)
                        report_mismatch($sformatf("result %0d remote_index %0h, want %0h",
                                                  results_checked, remote_index,
                                                  want.remote_index));
                    if (ready_res !== want.ready_res)
                        report_mismatch($sformatf("result %0d ready_res %0b, want %0b",
                                                  results_checked, ready_res,
                                                  want.ready_res));
                end
                results_checked++;
            end
            cyc++;
            // long hold-off now and then so the block backs up into in_ready
            if (hold == 0 && results_checked >= next_hold_at)
            begin
                hold = HOLD_OFF_CYCLES;
                next_hold_at += 500;
            end
            if (hold != 0)
            begin
                hold--;
                take = 1'b0;
            end
            else
            begin
                case ((cyc / 97) % 4)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 9) < 7);
                    2:       take = (cyc % 3 == 0);
                    default: take = ($urandom_range(0, 9) < 3);
                endcase
            end
            out_ready <= take;
        end
    end

    // Watchdog on cycles where no request moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        cfg_t              phase_limits [NUM_PHASES];
        int                phase_step [NUM_PHASES];
        req_t              rq;
        int                pick;
        logic [TIME_W-1:0] wall_clock;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_BEGIN;
        now_time       = '0;
        handshake_role = ROLE_NONE;
        local_index    = '0;
        peer_index     = '0;
        recv_count     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_REJECT_MSGS;
        cfg_data       = '0;

        foreach (kp_slots[i])
            kp_slots[i] = '0;
        limits = '{RST_REJECT_MSGS, RST_REKEY_MSGS, RST_REJECT_TIME, RST_REKEY_TIME};

        // limit settings: small, all zero, all max, random, two mixed
        phase_limits[0] = '{64'd8, 64'd4, 16'd20, 16'd10};
        phase_limits[1] = '{64'd0, 64'd0, 16'd0, 16'd0};
        phase_limits[2] = '{C_MAX, C_MAX, 16'hFFFF, 16'hFFFF};
        phase_limits[3] = '{64'($urandom_range(1, 40)), 64'($urandom_range(0, 40)),
                            16'($urandom_range(5, 200)), 16'($urandom_range(0, 200))};
        phase_limits[4] = '{C_MAX, 64'd3, 16'd60, 16'd0};
        phase_limits[5] = '{64'd2, 64'd5, 16'd300, 16'd30};
        phase_step[0] = 3;
        phase_step[1] = 1;
        phase_step[2] = 400;
        phase_step[3] = 8;
        phase_step[4] = 2;
        phase_step[5] = 5;

        // Directed table at reset limits; empty, rotation, age and counter edges
        add_row(OP_SEND,   32'd100, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_RECV,   32'd100, ROLE_NONE, 0, 0, 5, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd100, ROLE_NONE, 1, 2, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd100, ROLE_BAD,  1, 2, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BAD_LO, 32'd100, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BAD_HI, T_MAX,   ROLE_BAD,  '1, '1, C_MAX, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd100, ROLE_RESP, '1, 0, 0, 1, ST_OK, 0, 0, 0);
        add_row(OP_SEND,   32'd100, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd100, ROLE_INIT, 0, '1, 0, 1, ST_OK, 0, 0, 1);
        add_row(OP_SEND,   32'd100, ROLE_NONE, 0, 0, 0, 1, ST_OK, 0, '1, 1);
        // past the soft age, then past the hard age
        add_row(OP_SEND,   32'd221, ROLE_NONE, 0, 0, 0, 1, ST_FRESH, 1, '1, 1);
        add_row(OP_SEND,   32'd281, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        // birth at the top of the clock: no wrap in the age test
        add_row(OP_BEGIN,  T_MAX, ROLE_INIT, 5, 7, 0, 1, ST_OK, 0, 0, 1);
        add_row(OP_SEND,   T_MAX, ROLE_NONE, 0, 0, 0, 1, ST_OK, 0, 7, 1);
        add_row(OP_RECV,   T_MAX, ROLE_NONE, 0, 0, C_MAX, 1, ST_OK, 0, 0, 0);
        add_row(OP_SEND,   T_MAX, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_RECV,   T_MAX, ROLE_NONE, 0, 0, RST_REJECT_MSGS - 64'd1,
                1, ST_OK, 0, 0, 1);
        add_row(OP_SEND,   T_MAX, ROLE_NONE, 0, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(OP_EXPIRE, T_MAX, ROLE_NONE, 0, 0, 0, 1, ST_OK, 0, 0, 0);
        add_row(OP_SEND,   T_MAX, ROLE_NONE, 0, 0, 0, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd5, ROLE_RESP, 3, 4, 0, 1, ST_OK, 0, 0, 0);
        add_row(OP_EXPIRE, 32'd5, ROLE_NONE, 0, 0, 0, 1, ST_OK, 0, 0, 0);
        add_row(OP_CLEAR,  32'd5, ROLE_NONE, 0, 0, 0, 1, ST_OK, 0, 0, 0);
        add_row(OP_RECV,   32'd5, ROLE_NONE, 0, 0, 9, 1, ST_FAIL, 0, 0, 0);
        add_row(OP_BEGIN,  32'd0, ROLE_INIT, 1, 2, 0, 1, ST_OK, 0, 0, 1);
        add_row(OP_RECV,   32'd0, ROLE_NONE, 0, 0, 0, 0, ST_OK, 0, 0, 0);

        // Reset, then release
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            offer_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].res);
        in_valid <= 1'b0;
        drain_results();

        // Random phases, one limit setting each
        wall_clock = 32'd1000;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_limits(phase_limits[p]);
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // clock mostly creeps forward, sometimes jumps anywhere or to the top
                if ($urandom_range(0, 49) == 0)
                    wall_clock = $urandom;
                else if ($urandom_range(0, 99) == 0)
                    wall_clock = T_MAX - $urandom_range(0, 300);
                else
                    wall_clock += $urandom_range(0, phase_step[p]);
                rq.now_time = wall_clock;
                rq.local_index = $urandom;
                rq.peer_index = $urandom;
                rq.handshake_role = 2'($urandom_range(ROLE_NONE, ROLE_BAD));
                case ($urandom_range(0, 5))
                    0:       rq.recv_count = 64'($urandom_range(0, 10));
                    1:       rq.recv_count = limits.reject_msgs - 64'($urandom_range(0, 2));
                    2:       rq.recv_count = limits.reject_msgs + 64'($urandom_range(0, 2));
                    3:       rq.recv_count = {$urandom, $urandom};
                    4:       rq.recv_count = C_MAX;
                    default: rq.recv_count = '0;
                endcase
                // mostly meaningful ops, some unknown codes and raw noise
                pick = $urandom_range(0, 99);
                if (pick < 18)
                begin
                    rq.op = OP_BEGIN;
                    pick = $urandom_range(0, 19);
                    rq.handshake_role = (pick < 9)  ? ROLE_INIT :
                                        (pick < 16) ? ROLE_RESP :
                                        (pick < 18) ? ROLE_NONE : ROLE_BAD;
                end
                else if (pick < 23)
                    rq.op = OP_EXPIRE;
                else if (pick < 25)
                    rq.op = OP_CLEAR;
                else if (pick < 80)
                    rq.op = OP_SEND;
                else if (pick < 92)
                    rq.op = OP_RECV;
                else if (pick < 96)
                    rq.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
                else
                    rq.op = 3'($urandom_range(OP_BEGIN, OP_BAD_HI));
                offer_request(rq, 1'b0, '0);
            end
            in_valid <= 1'b0;
            drain_results();
        end

        $display("covered %0d requests over %0d limit settings, %0d sends (%0d refused)",
                 requests_sent, NUM_PHASES + 1, sends_total, sends_refused);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ session_keypair_rotation_top.f @@
rtl/skr_pkg.sv
rtl/skr_cfg.sv
rtl/skr_in_stage.sv
rtl/skr_exec.sv
rtl/session_keypair_rotation_top.sv
tb/testbench.sv
